// ===== rtl/assert_macros.svh =====
// Assertion helpers for the fade gain block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LPFG_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpfg assertion failed");

// Checked at every edge, reset included.
`define LPFG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lpfg assertion failed");

`endif

// ===== rtl/lpfg_pkg.sv =====
`default_nettype none
package lpfg_pkg;

  localparam int unsigned POW_W      = 40;
  localparam int unsigned CLIP_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_START_POWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX    = 2'd2;

  localparam logic [CLIP_W-1:0] CLIP_MAX_RESET = 15'h7FFF;

endpackage
`default_nettype wire

// ===== rtl/lpfg_if.sv =====
`default_nettype none
interface lpfg_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface lpfg_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] faded_sample;
  logic                          clipped;

  modport source (output valid, output faded_sample, output clipped, input ready);
  modport sink (input valid, input faded_sample, input clipped, output ready);
endinterface
`default_nettype wire

// ===== rtl/linear_power_fade_gain_top.sv =====
`default_nettype none
`include "assert_macros.svh"
// Power-ramp fade: each sample is scaled by the square root of a running Q8.32
// power level that moves by fade_rate (clamped to [0, 2^40-1]) before every
// sample, or restarts from start_power first when restart is set. Product is
// truncated toward zero and clipped to +-clip_max, with a clip flag. A beat
// passes from acceptance to result through the power update, the bit-serial
// square-root unit (start, ROOT_W steps, done; ROOT_W = 20 at the default
// POWER_FRAC_BITS = 32), one multiply and one clip stage. The input is not
// ready while a beat is in work, so a new beat is taken only once the last one
// has left the clip stage. The result sits in an output register, so the next
// beat may be accepted while it waits; a result still unread when the next one
// is due holds the block in its clip stage. Config must be written only while
// idle; the block itself does not enforce it.
module linear_power_fade_gain_top #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned POWER_FRAC_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [lpfg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [lpfg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lpfg_in_if.sink                                  in_i,
  lpfg_out_if.source                               out_o
);
  localparam int unsigned PW     = lpfg_pkg::POW_W;
  localparam int unsigned CW     = lpfg_pkg::CLIP_W;
  localparam int unsigned RF     = (POWER_FRAC_BITS + 1) / 2;
  localparam int unsigned RADSH  = 2 * RF - POWER_FRAC_BITS;
  localparam int unsigned ROOT_W = (PW + RADSH + 1) / 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned PROD_W = SAMPLE_BITS + ROOT_W;
  localparam int unsigned MAG_W  = PROD_W - RF;
  localparam int unsigned CMP_W  = (MAG_W > CW) ? MAG_W : CW;
  localparam logic [PW:0] ONE_EXT   = (PW+1)'(1) << POWER_FRAC_BITS;
  localparam logic [PW-1:0] UNITY   = ONE_EXT[PW-1:0];

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POW  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [PW-1:0]          start_power_q;
  logic [PW-1:0]          fade_rate_q;
  logic [CW-1:0]          clip_max_q;
  logic [SAMPLE_BITS-1:0] mag_q;
  logic                   neg_q;
  logic                   restart_q;
  logic [PROD_W-1:0]      prod_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic                   out_clip_q;

  logic                   in_ready;
  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] s_raw;
  logic [SAMPLE_BITS-1:0] mag_in;
  logic [PW-1:0]          power;
  logic [RAD_W-1:0]       radicand;
  logic                   sqrt_start;
  logic                   sqrt_busy;
  logic                   sqrt_done;
  logic [ROOT_W-1:0]      root;
  logic [CMP_W-1:0]       mag_x;
  logic [CMP_W-1:0]       clip_x;
  logic                   clip;
  logic [SAMPLE_BITS-1:0] mag_f;
  logic                   fin_go;

  assign in_ready = (state_q == S_IDLE);
  assign in_fire  = in_i.valid && in_ready;
  assign s_raw    = in_i.sample;
  assign mag_in   = s_raw[SAMPLE_BITS-1] ? (~s_raw + SAMPLE_BITS'(1)) : s_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_power_q <= UNITY;
      fade_rate_q   <= '0;
      clip_max_q    <= lpfg_pkg::CLIP_MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpfg_pkg::REG_START_POWER: start_power_q <= cfg_data_i[PW-1:0];
        lpfg_pkg::REG_FADE_RATE:   fade_rate_q   <= cfg_data_i[PW-1:0];
        lpfg_pkg::REG_CLIP_MAX:    clip_max_q    <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  lpfg_power #(
    .RESET_POWER (UNITY)
  ) u_power (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (state_q == S_POW),
    .restart_i     (restart_q),
    .start_power_i (start_power_q),
    .fade_rate_i   (fade_rate_q),
    .power_o       (power)
  );

  assign sqrt_start = (state_q == S_SQRT) && !sqrt_busy && !sqrt_done;
  assign radicand   = RAD_W'(power) << RADSH;

  lpfg_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .busy_o     (sqrt_busy),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // clip stage
  always_comb begin
    mag_x  = CMP_W'(prod_q[PROD_W-1:RF]);
    clip_x = CMP_W'(clip_max_q);
    clip   = mag_x > clip_x;
    mag_f  = clip ? clip_x[SAMPLE_BITS-1:0] : mag_x[SAMPLE_BITS-1:0];
  end

  assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_POW;
      S_POW:  state_d = S_SQRT;
      S_SQRT: if (sqrt_done) state_d = S_MUL;
      S_MUL:  state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q     <= mag_in;
      neg_q     <= s_raw[SAMPLE_BITS-1];
      restart_q <= in_i.restart;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(root);
    end
    if (fin_go) begin
      out_sample_q <= neg_q ? (~mag_f + SAMPLE_BITS'(1)) : mag_f;
      out_clip_q   <= clip;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.faded_sample = out_sample_q;
  assign out_o.clipped      = out_clip_q;

  `LPFG_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !in_i.ready)
  `LPFG_ASSERT(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_FIN))
  `LPFG_ASSERT(a_root_done_in_sqrt, clk_i, rst_ni, sqrt_done |-> state_q == S_SQRT)
  `LPFG_ASSERT_ALWAYS(a_idle_unit_free, clk_i, in_ready |-> !sqrt_busy)
endmodule
`default_nettype wire

// ===== rtl/lpfg_power.sv =====
`default_nettype none
module lpfg_power #(
  parameter logic [lpfg_pkg::POW_W-1:0] RESET_POWER = '0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       update_i,
  input  wire logic                       restart_i,
  input  wire logic [lpfg_pkg::POW_W-1:0] start_power_i,
  input  wire logic [lpfg_pkg::POW_W-1:0] fade_rate_i,
  output logic      [lpfg_pkg::POW_W-1:0] power_o
);
  localparam int unsigned PW = lpfg_pkg::POW_W;

  logic [PW-1:0] power_q, power_d;
  logic [PW-1:0] base;
  logic [PW+1:0] sum;

  // signed sum, two guard bits: top bit set is below zero, next one is overflow
  always_comb begin
    base = restart_i ? start_power_i : power_q;
    sum  = {2'b00, base} + {{2{fade_rate_i[PW-1]}}, fade_rate_i};
    if (sum[PW+1]) begin
      power_d = '0;
    end else if (sum[PW]) begin
      power_d = '1;
    end else begin
      power_d = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= RESET_POWER;
    end else if (update_i) begin
      power_q <= power_d;
    end
  end

  assign power_o = power_q;
endmodule
`default_nettype wire

// ===== rtl/lpfg_sqrt.sv =====
`default_nettype none
module lpfg_sqrt #(
  parameter int unsigned ROOT_W = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2*ROOT_W-1:0] radicand_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic      [ROOT_W-1:0]   root_o
);
  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+3:0] diff;

  // one restoring step: bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    diff   = {1'b0, rem_sh} - {2'b00, root_q, 2'b01};
    if (!diff[ROOT_W+3]) begin
      rem_d  = diff[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [lpfg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [lpfg_pkg::POW_W-1:0] UNITY_POWER = 40'h01_0000_0000;
  localparam logic [lpfg_pkg::POW_W-1:0] POWER_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [lpfg_pkg::POW_W-1:0] RATE_MAX_UP = 40'h7F_FFFF_FFFF;
  localparam logic [lpfg_pkg::POW_W-1:0] RATE_MAX_DOWN = 40'h80_0000_0000;

  typedef struct packed {
    logic signed [15:0] faded;
    logic               clipped;
  } fade_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_we = 1'b0;
  logic [lpfg_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [lpfg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic               tx_valid = 1'b0;
  logic signed [15:0] tx_sample = '0;
  logic               tx_restart = 1'b0;
  logic               rx_ready = 1'b0;

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;

  // predictor copy of the block's registers and power level
  logic [lpfg_pkg::POW_W-1:0]  start_pwr = UNITY_POWER;
  logic [lpfg_pkg::POW_W-1:0]  fade_rt = '0;
  logic [lpfg_pkg::CLIP_W-1:0] clip_lim = lpfg_pkg::CLIP_MAX_RESET;
  logic [lpfg_pkg::POW_W-1:0]  power_lvl = UNITY_POWER;

  fade_beat_t expected_q[$];

  lpfg_in_if #(.SAMPLE_BITS(16)) in_bus ();
  lpfg_out_if #(.SAMPLE_BITS(16)) out_bus ();

  assign in_bus.valid = tx_valid;
  assign in_bus.sample = tx_sample;
  assign in_bus.restart = tx_restart;
  assign out_bus.ready = rx_ready;

  linear_power_fade_gain_top #(
    .SAMPLE_BITS(16),
    .POWER_FRAC_BITS(32)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i(in_bus),
    .out_o(out_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [19:0] floor_sqrt(input logic [39:0] v);
    logic [19:0] r;
    logic [19:0] t;
    r = '0;
    for (int i = 19; i >= 0; i--) begin
      t = r | (20'd1 << i);
      if (40'(t) * 40'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic fade_beat_t next_faded(input logic signed [15:0] smp, input logic rs);
    logic [40:0] dec;
    logic [40:0] sum;
    logic [16:0] mag_in;
    logic [19:0] gain;
    logic [36:0] mag;
    fade_beat_t r;
    if (rs) power_lvl = start_pwr;
    if (fade_rt[lpfg_pkg::POW_W-1]) begin
      dec = 41'h100_0000_0000 - {1'b0, fade_rt};
      power_lvl = ({1'b0, power_lvl} >= dec) ? power_lvl - dec[39:0] : '0;
    end else begin
      sum = {1'b0, power_lvl} + {1'b0, fade_rt};
      power_lvl = sum[40] ? POWER_MAX : sum[39:0];
    end
    gain = floor_sqrt(power_lvl);
    mag_in = smp[15] ? 17'd0 - {1'b1, smp} : {1'b0, smp};
    mag = (37'(mag_in) * 37'(gain)) >> 16;
    r.clipped = mag > 37'(clip_lim);
    if (r.clipped) mag = 37'(clip_lim);
    r.faded = smp[15] ? 16'd0 - mag[15:0] : mag[15:0];
    return r;
  endfunction

  function automatic logic [39:0] rand40();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[39:0];
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 4)) - 2);
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 40)
      $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    fade_beat_t want;
    if (rst_ni && out_bus.valid && rx_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, faded_sample", 0, int'(out_bus.faded_sample));
      end else begin
        want = expected_q.pop_front();
        if (out_bus.faded_sample !== want.faded)
          report_mismatch("faded_sample", int'(want.faded), int'(out_bus.faded_sample));
        if (out_bus.clipped !== want.clipped)
          report_mismatch("clipped", int'(want.clipped), int'(out_bus.clipped));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      rx_ready <= (rx_hold == 1);
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      rx_hold <= $urandom_range(1, 8);
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tx_valid && in_bus.ready) || (out_bus.valid && rx_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic signed [15:0] smp, input logic rs);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      tx_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    tx_valid <= 1'b1;
    tx_sample <= smp;
    tx_restart <= rs;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_q.push_back(next_faded(smp, rs));
  endtask

  task automatic wait_for_results();
    if (tx_valid) tx_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lpfg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lpfg_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      lpfg_pkg::REG_START_POWER: start_pwr = data;
      lpfg_pkg::REG_FADE_RATE:   fade_rt = data;
      lpfg_pkg::REG_CLIP_MAX:    clip_lim = data[lpfg_pkg::CLIP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [39:0] sp, input logic [39:0] rate,
                                input logic [39:0] clip);
    wait_for_results();
    write_reg(lpfg_pkg::REG_START_POWER, sp);
    write_reg(lpfg_pkg::REG_FADE_RATE, rate);
    write_reg(lpfg_pkg::REG_CLIP_MAX, clip);
  endtask

  task automatic apply_random_settings(input bit gentle);
    logic [39:0] sp;
    logic [39:0] rate;
    logic [39:0] clip;
    case ($urandom_range(0, 9))
      0: sp = '0;
      1: sp = POWER_MAX;
      default: sp = rand40() >> $urandom_range(0, gentle ? 12 : 39);
    endcase
    case ($urandom_range(0, 11))
      0: rate = RATE_MAX_UP;
      1: rate = RATE_MAX_DOWN;
      2: rate = '0;
      default: begin
        rate = rand40() >> $urandom_range(gentle ? 8 : 1, 39);
        if ($urandom_range(0, 1)) rate = 40'd0 - rate;
      end
    endcase
    case ($urandom_range(0, 5))
      0: clip = 40'(lpfg_pkg::CLIP_MAX_RESET);
      1: clip = rand40();
      2: clip = 40'd1;
      default: clip = 40'($urandom_range(0, 32767));
    endcase
    apply_settings(sp, rate, clip);
    if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, rand40());
  endtask

  task automatic test_unity_gain();
    send_beat(16'sd0, 1'b1);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(-16'sh8000, 1'b0);
    send_beat(-16'sd1, 1'b0);
    send_beat(16'sd1, 1'b0);
    send_beat(16'sd12345, 1'b0);
  endtask

  task automatic test_special_cases();
    // power saturates at the top
    apply_settings(POWER_MAX, RATE_MAX_UP, 40'(lpfg_pkg::CLIP_MAX_RESET));
    send_beat(16'sd100, 1'b1);
    send_beat(-16'sh8000, 1'b0);
    // power floors at zero
    apply_settings(UNITY_POWER, RATE_MAX_DOWN, 40'(lpfg_pkg::CLIP_MAX_RESET));
    send_beat(16'sh7FFF, 1'b1);
    send_beat(-16'sh8000, 1'b0);
    apply_settings('0, '0, 40'(lpfg_pkg::CLIP_MAX_RESET));
    send_beat(16'sh7FFF, 1'b1);
    // upper bits dropped, leaving a zero clip limit
    apply_settings(UNITY_POWER, '0, 40'hFF_FFFF_8000);
    send_beat(16'sd1, 1'b1);
    send_beat(16'sd0, 1'b0);
    send_beat(-16'sd5, 1'b0);
    apply_settings(UNITY_POWER, '0, 40'd1);
    send_beat(16'sd2, 1'b0);
    send_beat(-16'sd1, 1'b0);
    // write beyond the register list must leave everything alone
    wait_for_results();
    write_reg(REG_UNUSED, POWER_MAX);
    send_beat(-16'sd3, 1'b0);
    // ramp down through zero
    apply_settings(UNITY_POWER, 40'd0 - 40'h00_4000_0000, 40'(lpfg_pkg::CLIP_MAX_RESET));
    send_beat(16'sd20000, 1'b1);
    repeat (4) send_beat(16'sd20000, 1'b0);
  endtask

  task automatic test_fade_ramps();
    repeat (12) begin
      tx_gaps = $urandom_range(0, 2) != 0;
      rx_stalls = $urandom_range(0, 2) != 0;
      apply_random_settings(1'b1);
      send_beat(rand_sample(), 1'b1);
      repeat (24) send_beat(rand_sample(), 1'b0);
    end
  endtask

  task automatic test_random_stream();
    int unsigned left;
    int unsigned n;
    left = 450;
    while (left != 0) begin
      tx_gaps = $urandom_range(0, 2) != 0;
      rx_stalls = $urandom_range(0, 2) != 0;
      apply_random_settings(1'($urandom_range(0, 1)));
      n = $urandom_range(20, 60);
      if (n > left) n = left;
      left -= n;
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) wait_for_results();
        send_beat(rand_sample(), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  task automatic test_back_to_back();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    apply_random_settings(1'b1);
    send_beat(rand_sample(), 1'b1);
    repeat (79) send_beat(rand_sample(), $urandom_range(0, 15) == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unity_gain();
    test_special_cases();
    test_fade_ramps();
    test_random_stream();
    test_back_to_back();
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
